>>> rtl/uotf_pkg.sv
// ----------------------------------------------------------------------------
// uotf_pkg
// Shared types and constants for the oversampled UART with receive ring.
// ----------------------------------------------------------------------------
package uotf_pkg;

    // Field widths fixed by the word format.
    localparam int TICKS_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 5;
    localparam int FRAME_W  = 10;
    localparam int RXTMR_W  = 5;
    localparam int BITCNT_W = 4;

    // Default ring depth.
    localparam int RING_DEPTH_DEF = 16;

    // Frame and filter constants.
    localparam logic [BITCNT_W-1:0] FRAME_BITS = 4'd10;
    localparam logic [BITCNT_W-1:0] DATA_BITS  = 4'd8;
    localparam logic [BYTE_W-1:0]   DROP_BYTE_A = 8'hC2;
    localparam logic [BYTE_W-1:0]   DROP_BYTE_B = 8'h0A;

    // Register reset values.
    localparam logic [TICKS_W-1:0] TPB_RESET   = 4'd3;
    localparam logic               RX_EN_RESET = 1'b1;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_POP  = 2'd2
    } t_cmd;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DROP  = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TICKS = 1'b0,
        CFG_RX_EN = 1'b1
    } t_cfg_index;

    // Input word.
    typedef struct packed {
        t_cmd              cmd;
        logic              rx_line;
        logic [BYTE_W-1:0] tx_byte;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic               tx_line;
        logic               tx_busy;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_valid;
        t_status            status;
        logic [LEVEL_W-1:0] rx_level;
    } t_out_word;

    // Transmitter state after an item.
    typedef struct packed {
        logic line;
        logic busy;
        logic refused;
    } t_tx_state;

    // Receiver request to store a byte.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_rx_store;

    // Ring status for the current item.
    typedef struct packed {
        logic dropped;
        logic empty;
        logic popped;
    } t_ring_stat;

    // A zero period is taken as one tick.
    function automatic logic [TICKS_W-1:0] bit_period(input logic [TICKS_W-1:0] tpb);
        bit_period = (tpb == '0) ? TICKS_W'(1) : tpb;
    endfunction

endpackage

>>> rtl/uotf_ram.sv
// ----------------------------------------------------------------------------
// uotf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module uotf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/uotf_tx.sv
// ----------------------------------------------------------------------------
// uotf_tx
// Transmit serializer: shifts a start, eight data and a stop bit per frame.
// ----------------------------------------------------------------------------
module uotf_tx
    import uotf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_send,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic [TICKS_W-1:0] i_tpb,
    output t_tx_state          o_state
);

    logic [FRAME_W-1:0]  r_shift, n_shift;
    logic [TICKS_W-1:0]  r_timer, n_timer;
    logic [BITCNT_W-1:0] r_bits_left, n_bits_left;
    logic                r_active, n_active;
    logic                r_level, n_level;
    logic [TICKS_W-1:0]  timer_dec;
    logic [BITCNT_W-1:0] bits_dec;

    assign timer_dec = r_timer - TICKS_W'(1);
    assign bits_dec  = r_bits_left - BITCNT_W'(1);

    // Next state for ticks and sends.
    always_comb begin
        n_shift     = r_shift;
        n_timer     = r_timer;
        n_bits_left = r_bits_left;
        n_active    = r_active;
        n_level     = r_level;
        if (i_tick && r_active) begin
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                n_level     = r_shift[0];
                n_shift     = {1'b0, r_shift[FRAME_W-1:1]};
                n_timer     = bit_period(i_tpb);
                n_bits_left = bits_dec;
                if (bits_dec == '0) begin
                    n_active = 1'b0;
                    n_level  = 1'b1;
                end
            end
        end else if (i_send && !r_active) begin
            n_timer     = bit_period(i_tpb);
            n_bits_left = FRAME_BITS;
            n_shift     = {1'b1, i_byte, 1'b0};
            n_active    = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_timer     <= '0;
            r_bits_left <= '0;
            r_active    <= 1'b0;
            r_level     <= 1'b1;
        end else begin
            r_shift     <= n_shift;
            r_timer     <= n_timer;
            r_bits_left <= n_bits_left;
            r_active    <= n_active;
            r_level     <= n_level;
        end
    end

    assign o_state.line    = n_level;
    assign o_state.busy    = n_active;
    assign o_state.refused = i_send && r_active;

`ifndef ASSERT_OFF
    // A running frame always has bits left to send.
    a_active_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bits_left != '0))
        else $error("transmitter active with no bits left");
`endif

endmodule

>>> rtl/uotf_rx.sv
// ----------------------------------------------------------------------------
// uotf_rx
// Receive deserializer: finds a start level, samples eight bits, waits out
// the stop bit and requests a store of the byte unless it is filtered.
// ----------------------------------------------------------------------------
module uotf_rx
    import uotf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_line,
    input  logic               i_enable,
    input  logic [TICKS_W-1:0] i_tpb,
    output t_rx_store          o_store
);

    logic                r_active, n_active;
    logic                r_wait_stop, n_wait_stop;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [BITCNT_W-1:0] r_bits_left, n_bits_left;
    logic [RXTMR_W-1:0]  r_timer, n_timer;
    logic [RXTMR_W-1:0]  timer_dec;
    logic [BITCNT_W-1:0] bits_dec;
    logic                done;

    assign timer_dec = r_timer - RXTMR_W'(1);
    assign bits_dec  = r_bits_left - BITCNT_W'(1);

    // Next state on a tick while enabled.
    always_comb begin
        n_active    = r_active;
        n_wait_stop = r_wait_stop;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_timer     = r_timer;
        done        = 1'b0;
        if (i_tick && i_enable) begin
            if (r_wait_stop) begin
                n_timer = timer_dec;
                if (timer_dec == '0) begin
                    n_wait_stop = 1'b0;
                    n_active    = 1'b0;
                    done        = 1'b1;
                end
            end else if (!r_active) begin
                if (!i_line) begin
                    n_active    = 1'b1;
                    n_shift     = '0;
                    n_timer     = RXTMR_W'(bit_period(i_tpb)) + RXTMR_W'(1);
                    n_bits_left = DATA_BITS;
                end
            end else begin
                n_timer = timer_dec;
                if (timer_dec == '0) begin
                    n_timer     = RXTMR_W'(bit_period(i_tpb));
                    n_shift     = {i_line, r_shift[BYTE_W-1:1]};
                    n_bits_left = bits_dec;
                    if (bits_dec == '0) begin
                        n_wait_stop = 1'b1;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_wait_stop <= 1'b0;
            r_shift     <= '0;
            r_bits_left <= '0;
            r_timer     <= '0;
        end else begin
            r_active    <= n_active;
            r_wait_stop <= n_wait_stop;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_timer     <= n_timer;
        end
    end

    // Filtered bytes never reach the ring.
    assign o_store.valid = done && (r_shift != DROP_BYTE_A) && (r_shift != DROP_BYTE_B);
    assign o_store.data  = r_shift;

endmodule

>>> rtl/uotf_ring.sv
// ----------------------------------------------------------------------------
// uotf_ring
// Receive ring: pointers and fill count around one RAM. A store and a pop
// never fall in the same item, so the RAM needs no forwarding.
// ----------------------------------------------------------------------------
module uotf_ring
    import uotf_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_rx_store                  i_store,
    input  logic                       i_pop,
    output t_ring_stat                 o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_fill,
    output logic [BYTE_W-1:0]          o_rdata
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              full;
    logic              empty;
    logic              we;
    logic              re;

    assign full  = (r_fill == FILL_W'(DEPTH));
    assign empty = (r_fill == '0);
    assign we    = i_store.valid && !full;
    assign re    = i_pop && !empty;

    // Pointer and count updates.
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (we) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            n_fill = r_fill + FILL_W'(1);
        end
        if (re) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    // Byte storage.
    uotf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wptr),
        .i_wdata (i_store.data),
        .i_re    (re),
        .i_raddr (r_rptr),
        .o_rdata (o_rdata)
    );

    assign o_stat.dropped = i_store.valid && full;
    assign o_stat.empty   = i_pop && empty;
    assign o_stat.popped  = re;
    assign o_fill         = n_fill;

`ifndef ASSERT_OFF
    // The count never passes the depth.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("ring count above depth");

    // An empty ring has its pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wptr == r_rptr))
        else $error("empty ring with pointers apart");

    // A pop and a store never share one item.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re))
        else $error("ring write and read in one cycle");
`endif

endmodule

>>> rtl/oversampled_uart_txrx_fifo.sv
// ----------------------------------------------------------------------------
// oversampled_uart_txrx_fifo
// 8N1 UART paced by oversampling ticks, with a receive ring of bytes.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries a command: tick, send a byte, or pop a received
// byte. Every accepted word yields exactly one output word holding the
// transmit line, the busy flag, a popped byte, a status code and the ring
// fill level after that command.
// The configuration port writes ticks_per_bit (index 0) and rx_enable
// (index 1); write it only while no word is in flight.
// An accepted word passes the result stage, then the output register. One
// word is accepted per cycle unless the output stalls: the transmitter,
// receiver and ring pointers all update in the accepting cycle, and the
// popped byte arrives from the ring RAM's registered read in the next one.
// A result stage and an output register sit between the sides, so one
// more word is taken while the output is stalled; then ready drops.
// After reset the transmit line is high, both directions are idle, the
// ring is empty, ticks_per_bit is 3 and the receiver is enabled. Ring
// contents are not cleared; only entries written since reset are read.
// ----------------------------------------------------------------------------
module oversampled_uart_txrx_fifo
    import uotf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_index        i_cfg_index,
    input  logic [TICKS_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out
);

    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    // Result stage contents before the popped byte is attached.
    typedef struct packed {
        logic               tx_line;
        logic               tx_busy;
        logic               rx_valid;
        t_status            status;
        logic [LEVEL_W-1:0] rx_level;
    } t_res_word;

    logic [TICKS_W-1:0] r_tpb;
    logic               r_rx_en;
    logic               r_a_valid;
    t_res_word          r_a, n_a;
    logic               r_o_valid;
    t_out_word          r_o;
    logic               accept;
    logic               a_move;
    logic               do_tick;
    logic               do_send;
    logic               do_pop;
    t_tx_state          tx_state;
    t_rx_store          rx_store;
    t_ring_stat         ring_stat;
    logic [FILL_W-1:0]  fill;
    logic [BYTE_W-1:0]  ram_rdata;

    // Handshake and command decode.
    assign a_move     = r_a_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || a_move;
    assign accept     = i_in_valid && o_in_ready;
    assign do_tick    = accept && (i_in.cmd == CMD_TICK);
    assign do_send    = accept && (i_in.cmd == CMD_SEND);
    assign do_pop     = accept && (i_in.cmd == CMD_POP);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb   <= TPB_RESET;
            r_rx_en <= RX_EN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS: r_tpb   <= i_cfg_data;
                CFG_RX_EN: r_rx_en <= i_cfg_data[0];
                default:   r_tpb   <= r_tpb;
            endcase
        end
    end

    uotf_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (do_tick),
        .i_send  (do_send),
        .i_byte  (i_in.tx_byte),
        .i_tpb   (r_tpb),
        .o_state (tx_state)
    );

    uotf_rx u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (do_tick),
        .i_line   (i_in.rx_line),
        .i_enable (r_rx_en),
        .i_tpb    (r_tpb),
        .o_store  (rx_store)
    );

    uotf_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_store (rx_store),
        .i_pop   (do_pop),
        .o_stat  (ring_stat),
        .o_fill  (fill),
        .o_rdata (ram_rdata)
    );

    // Status and fields of the current word.
    always_comb begin
        n_a.tx_line  = tx_state.line;
        n_a.tx_busy  = tx_state.busy;
        n_a.rx_valid = ring_stat.popped;
        n_a.rx_level = LEVEL_W'(fill);
        case (i_in.cmd)
            CMD_TICK: n_a.status = ring_stat.dropped ? ST_DROP : ST_OK;
            CMD_SEND: n_a.status = tx_state.refused ? ST_BUSY : ST_OK;
            CMD_POP:  n_a.status = ring_stat.empty ? ST_EMPTY : ST_OK;
            default:  n_a.status = ST_OK;
        endcase
    end

    // Result stage: holds the word while the RAM read data is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= n_a;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o.tx_line  <= r_a.tx_line;
            r_o.tx_busy  <= r_a.tx_busy;
            r_o.rx_byte  <= r_a.rx_valid ? ram_rdata : '0;
            r_o.rx_valid <= r_a.rx_valid;
            r_o.status   <= r_a.status;
            r_o.rx_level <= r_a.rx_level;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_o;

`ifndef ASSERT_OFF
    // With both stages full and the output stalled, no word may enter.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_o_valid && !i_out_ready) |-> !o_in_ready)
        else $error("word accepted while both stages are held");
`endif

endmodule
